### rtl/gjdc_pkg.sv
package gjdc_pkg;

  localparam logic [21:0] JDN_LOW    = 22'd2378862;
  localparam logic [21:0] JDN_HIGH   = 22'd2488069;
  localparam logic [16:0] SECS_MAX   = 17'd86399;

  // floor(x / 60) == (x * RECIP60) >> RECIP60_SH for every x below 86400
  localparam logic [17:0] RECIP60    = 18'd139811;
  localparam int unsigned RECIP60_SH = 23;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } hms_t;

  // floor(275 * m / 9)
  function automatic logic [8:0] div275_9(input logic [3:0] m);
    logic [8:0] r;
    unique case (m)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd30;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd91;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd152;
      4'd6:    r = 9'd183;
      4'd7:    r = 9'd213;
      4'd8:    r = 9'd244;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd305;
      4'd11:   r = 9'd336;
      4'd12:   r = 9'd366;
      4'd13:   r = 9'd397;
      4'd14:   r = 9'd427;
      default: r = 9'd458;
    endcase
    return r;
  endfunction

  // floor(2447 * j / 80)
  function automatic logic [8:0] div2447_80(input logic [3:0] j);
    logic [8:0] r;
    unique case (j)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd30;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd91;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd152;
      4'd6:    r = 9'd183;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd244;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd305;
      4'd11:   r = 9'd336;
      4'd12:   r = 9'd367;
      4'd13:   r = 9'd397;
      4'd14:   r = 9'd428;
      default: r = 9'd458;
    endcase
    return r;
  endfunction

endpackage

### rtl/gjdc_hms.sv
module gjdc_hms (
  input  logic          clk,
  input  logic [16:0]   secs,
  output gjdc_pkg::hms_t hms
);
  import gjdc_pkg::*;

  logic [10:0] mt_r, mt_nxt;
  logic [16:0] sa_r, sa_nxt;
  logic [5:0]  sv_r, sv_nxt;
  logic [4:0]  hq_r, hq_nxt;
  logic [10:0] mtb_r, mtb_nxt;
  hms_t        hms_r, hms_nxt;

  // minutes of day
  always_comb begin
    mt_nxt = 11'((35'(secs) * 35'(RECIP60)) >> RECIP60_SH);
    sa_nxt = secs;
  end

  // seconds and hours
  always_comb begin
    sv_nxt  = 6'(sa_r - 17'(mt_r) * 17'd60);
    hq_nxt  = 5'((29'(mt_r) * 29'(RECIP60)) >> RECIP60_SH);
    mtb_nxt = mt_r;
  end

  always_comb begin
    hms_nxt.hour   = hq_r;
    hms_nxt.minute = 6'(mtb_r - 11'(hq_r) * 11'd60);
    hms_nxt.second = sv_r;
  end

  always_ff @(posedge clk) begin
    mt_r  <= mt_nxt;
    sa_r  <= sa_nxt;
    sv_r  <= sv_nxt;
    hq_r  <= hq_nxt;
    mtb_r <= mtb_nxt;
    hms_r <= hms_nxt;
  end

  assign hms = hms_r;

endmodule

### rtl/gregorian_julian_day_convert_core.sv
// channel  | transfer                        | payload
// ---------+---------------------------------+----------------------------------------
// input    | start && !busy at rising edge   | in_mode, in_year .. in_second_of_day
// result   | out_valid, one cycle, no stall  | out_day_number_out .. out_in_range
//
// one transaction can enter every cycle while busy is low; each passes through the
// eight-stage day-number to date chain (two reciprocal divisions, each a multiply
// stage followed by a correction stage)
// busy is high during reset and until the first clock edge after it, low from then on
// synchronous active-low reset clears the valid bits; data registers are not reset
// the receiver cannot stall, so nothing in the pipeline ever holds
module gregorian_julian_day_convert_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_mode,
  input  logic [11:0] in_year,
  input  logic [3:0]  in_month,
  input  logic [4:0]  in_day,
  input  logic [4:0]  in_hour,
  input  logic [5:0]  in_minute,
  input  logic [5:0]  in_second,
  input  logic [21:0] in_day_number,
  input  logic [16:0] in_second_of_day,
  output logic        out_valid,
  output logic [21:0] out_day_number_out,
  output logic [16:0] out_seconds_out,
  output logic [11:0] out_year_out,
  output logic [3:0]  out_month_out,
  output logic [4:0]  out_day_out,
  output logic [4:0]  out_hour_out,
  output logic [5:0]  out_minute_out,
  output logic [5:0]  out_second_out,
  output logic        out_in_range
);
  import gjdc_pkg::*;

  localparam int unsigned NSTG    = 8;
  localparam int unsigned NN_BASE = 67;

  localparam logic [22:0] L_OFS   = 23'd68569;
  localparam logic [24:0] TH_NN1  = 25'((NN_BASE + 1) * 146097);
  localparam logic [24:0] TH_NN2  = 25'((NN_BASE + 2) * 146097);
  localparam logic [22:0] OFS_NN0 = 23'((146097 * NN_BASE + 3) / 4);
  localparam logic [22:0] OFS_NN1 = 23'((146097 * (NN_BASE + 1) + 3) / 4);
  localparam logic [22:0] OFS_NN2 = 23'((146097 * (NN_BASE + 2) + 3) / 4);
  localparam logic [11:0] YR_BASE = 12'(100 * (NN_BASE - 49));

  localparam logic [32:0] RECIP_YR    = 33'd45933;
  localparam int unsigned RECIP_YR_SH = 24;
  localparam logic [28:0] YR_DIV      = 29'd1461001;
  localparam logic [21:0] RECIP_MO    = 22'd2142;
  localparam int unsigned RECIP_MO_SH = 16;
  localparam logic [16:0] MO_DIV      = 17'd2447;

  localparam logic [22:0] BASE_LATE  = 23'd1721014;
  localparam logic [22:0] BASE_EARLY = 23'd1721015;

  typedef struct packed {
    logic        mode;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [21:0] dn;
    logic [16:0] secs;
    logic        ok;
    logic [20:0] a367;
    logic [1:0]  q12;
    logic [8:0]  p275;
    logic        late;
    logic [22:0] lv;
    logic [1:0]  nsel;
    logic [16:0] xv;
    logic [6:0]  iiv;
    logic [9:0]  l3;
    logic [3:0]  jv;
    hms_t        hms;
  } pipe_t;

  pipe_t         s_r   [1:NSTG];
  pipe_t         s_nxt [1:NSTG];
  logic [NSTG:1] v_r, v_nxt;
  logic          busy_r, busy_nxt;
  hms_t          hms_w;

  logic [4:0]  hc;
  logic [5:0]  mc, sc;
  logic [16:0] secs0, sd;
  logic [14:0] c7;
  logic [22:0] jdn0;
  logic [24:0] l4;
  logic [22:0] ofs;
  logic [28:0] x4000, qm;
  logic [9:0]  kd;
  logic        lw;
  logic [4:0]  jf;

  assign busy_nxt = 1'b0;
  assign v_nxt    = {v_r[NSTG-1:1], start && !busy_r};

  // input stage: saturation, constant products, range check
  always_comb begin
    hc    = (in_hour > 5'd23) ? 5'd23 : in_hour;
    mc    = (in_minute > 6'd59) ? 6'd59 : in_minute;
    sc    = (in_second > 6'd59) ? 6'd59 : in_second;
    secs0 = 17'(hc) * 17'd3600 + 17'(mc) * 17'd60 + 17'(sc);
    sd    = (in_second_of_day > SECS_MAX) ? SECS_MAX : in_second_of_day;

    s_nxt[1]        = '0;
    s_nxt[1].mode   = in_mode;
    s_nxt[1].year   = in_year;
    s_nxt[1].month  = in_month;
    s_nxt[1].day    = in_day;
    s_nxt[1].hour   = in_hour;
    s_nxt[1].minute = in_minute;
    s_nxt[1].second = in_second;
    s_nxt[1].dn     = in_day_number;
    s_nxt[1].secs   = in_mode ? sd : secs0;
    s_nxt[1].ok     = (in_day_number >= JDN_LOW) && (in_day_number <= JDN_HIGH);
    s_nxt[1].a367   = 21'(in_year) * 21'd367;
    s_nxt[1].q12    = (in_month >= 4'd15) ? 2'd2 : ((in_month >= 4'd3) ? 2'd1 : 2'd0);
    s_nxt[1].p275   = div275_9(in_month);
    s_nxt[1].late   = (19'(in_year) * 19'd100 + 19'(in_month)) >= 19'd190003;
    s_nxt[1].lv     = 23'(in_day_number) + L_OFS;
  end

  // date sum for mode 0, 400-year cycle for mode 1
  always_comb begin
    s_nxt[2] = s_r[1];
    c7   = 15'((15'(s_r[1].year) + 15'(s_r[1].q12)) * 15'd7) >> 2;
    jdn0 = 23'(s_r[1].a367) + 23'(s_r[1].p275) + 23'(s_r[1].day)
         + (s_r[1].late ? BASE_LATE : BASE_EARLY) - 23'(c7);
    l4   = {s_r[1].lv, 2'b00};
    if (l4 >= TH_NN2) begin
      s_nxt[2].nsel = 2'd2;
      ofs           = OFS_NN2;
    end else if (l4 >= TH_NN1) begin
      s_nxt[2].nsel = 2'd1;
      ofs           = OFS_NN1;
    end else begin
      s_nxt[2].nsel = 2'd0;
      ofs           = OFS_NN0;
    end
    s_nxt[2].xv = 17'(s_r[1].lv - ofs + 23'd1);
    if (!s_r[1].mode) begin
      s_nxt[2].dn = jdn0[21:0];
      s_nxt[2].ok = (jdn0 >= 23'(JDN_LOW)) && (jdn0 <= 23'(JDN_HIGH));
    end
  end

  // year within cycle: estimate
  always_comb begin
    s_nxt[3]     = s_r[2];
    s_nxt[3].iiv = 7'((33'(s_r[2].xv) * RECIP_YR) >> RECIP_YR_SH);
  end

  // year within cycle: correction
  always_comb begin
    s_nxt[4] = s_r[3];
    x4000    = 29'(s_r[3].xv) * 29'd4000;
    qm       = 29'(s_r[3].iiv) * YR_DIV;
    if (x4000 >= qm + YR_DIV) begin
      s_nxt[4].iiv = s_r[3].iiv + 7'd1;
    end
  end

  // day of shifted year
  always_comb begin
    s_nxt[5]     = s_r[4];
    s_nxt[5].l3  = 10'(18'(s_r[4].xv) - 18'd1
                 - ((18'(s_r[4].iiv) * 18'd1461) >> 2) + 18'd31);
    s_nxt[5].hms = hms_w;
  end

  // shifted month: estimate
  always_comb begin
    s_nxt[6]    = s_r[5];
    s_nxt[6].jv = 4'((22'(s_r[5].l3) * RECIP_MO) >> RECIP_MO_SH);
  end

  // shifted month: correction
  always_comb begin
    s_nxt[7] = s_r[6];
    if (17'(s_r[6].l3) * 17'd80 >= 17'(s_r[6].jv) * MO_DIV + MO_DIV) begin
      s_nxt[7].jv = s_r[6].jv + 4'd1;
    end
  end

  // result assembly
  always_comb begin
    s_nxt[8] = s_r[7];
    kd = s_r[7].l3 - 10'(div2447_80(s_r[7].jv));
    lw = s_r[7].jv >= 4'd11;
    jf = 5'(s_r[7].jv) + 5'd2 - (lw ? 5'd12 : 5'd0);
    if (s_r[7].mode) begin
      if (s_r[7].ok) begin
        s_nxt[8].year   = YR_BASE + 12'(s_r[7].nsel) * 12'd100
                        + 12'(s_r[7].iiv) + 12'(lw);
        s_nxt[8].month  = jf[3:0];
        s_nxt[8].day    = kd[4:0];
        s_nxt[8].hour   = s_r[7].hms.hour;
        s_nxt[8].minute = s_r[7].hms.minute;
        s_nxt[8].second = s_r[7].hms.second;
      end else begin
        s_nxt[8].dn     = '0;
        s_nxt[8].secs   = '0;
        s_nxt[8].year   = '0;
        s_nxt[8].month  = '0;
        s_nxt[8].day    = '0;
        s_nxt[8].hour   = '0;
        s_nxt[8].minute = '0;
        s_nxt[8].second = '0;
      end
    end
  end

  gjdc_hms u_hms (
    .clk  (clk),
    .secs (s_r[1].secs),
    .hms  (hms_w)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r    <= '0;
      busy_r <= 1'b1;
    end else begin
      v_r    <= v_nxt;
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 1; k <= NSTG; k++) begin
      s_r[k] <= s_nxt[k];
    end
  end

  assign busy               = busy_r;
  assign out_valid          = v_r[NSTG];
  assign out_day_number_out = s_r[NSTG].dn;
  assign out_seconds_out    = s_r[NSTG].secs;
  assign out_year_out       = s_r[NSTG].year;
  assign out_month_out      = s_r[NSTG].month;
  assign out_day_out        = s_r[NSTG].day;
  assign out_hour_out       = s_r[NSTG].hour;
  assign out_minute_out     = s_r[NSTG].minute;
  assign out_second_out     = s_r[NSTG].second;
  assign out_in_range       = s_r[NSTG].ok;

  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##8 out_valid)
    else $error("transaction did not reach the result port");

  a_secs_max : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_in_range) |-> (out_seconds_out <= SECS_MAX))
    else $error("seconds of day out of range");

  a_jdn_span : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_in_range) |->
      (out_day_number_out >= JDN_LOW && out_day_number_out <= JDN_HIGH))
    else $error("in_range set for day number outside span");

  a_mode1_flag : assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[1] && s_r[1].mode && s_r[1].ok) |-> ##7 out_in_range)
    else $error("valid day number lost its range flag");

  a_reset_quiet : assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> (!out_valid && busy))
    else $error("activity straight after reset");

endmodule
